// File: hw/rtl/thcc_pkg.sv
// ----------------------------------------------------------------------------
// thcc_pkg
// shared types, opcode fields and address decode for the harvard cpu cycle unit
// ----------------------------------------------------------------------------
package thcc_pkg;

   localparam int unsigned RAM_DEPTH = 65536;

   localparam logic [15:0] PAGE_MASK = 16'hff00;
   localparam logic [7:0]  HSYNC_BIT = 8'h40;
   localparam logic [7:0]  SIGN_BIT  = 8'h80;

   // alu op field, opcode bits 7..5
   localparam logic [2:0] OP_LD  = 3'd0;
   localparam logic [2:0] OP_AND = 3'd1;
   localparam logic [2:0] OP_OR  = 3'd2;
   localparam logic [2:0] OP_XOR = 3'd3;
   localparam logic [2:0] OP_ADD = 3'd4;
   localparam logic [2:0] OP_SUB = 3'd5;
   localparam logic [2:0] OP_ST  = 3'd6;
   localparam logic [2:0] OP_JMP = 3'd7;

   // addressing / destination mode, opcode bits 4..2
   localparam logic [2:0] MODE_D_AC    = 3'd0;
   localparam logic [2:0] MODE_X_AC    = 3'd1;
   localparam logic [2:0] MODE_YD_AC   = 3'd2;
   localparam logic [2:0] MODE_YX_AC   = 3'd3;
   localparam logic [2:0] MODE_D_X     = 3'd4;
   localparam logic [2:0] MODE_D_Y     = 3'd5;
   localparam logic [2:0] MODE_D_OUT   = 3'd6;
   localparam logic [2:0] MODE_YXI_OUT = 3'd7;

   // jump with mode zero is a far jump
   localparam logic [2:0] MODE_FAR = 3'd0;

   // bus source, opcode bits 1..0
   localparam logic [1:0] BUS_D   = 2'd0;
   localparam logic [1:0] BUS_RAM = 2'd1;
   localparam logic [1:0] BUS_AC  = 2'd2;
   localparam logic [1:0] BUS_IN  = 2'd3;

   typedef struct packed {
      logic [15:0] pc;
      logic [7:0]  ir;
      logic [7:0]  d;
      logic [7:0]  ac;
      logic [7:0]  x;
      logic [7:0]  y;
      logic [7:0]  out_port;
      logic [7:0]  ext_out;
   } arch_state_type;

   typedef struct packed {
      logic        we;
      logic [15:0] waddr;
      logic [7:0]  wdata;
      logic [15:0] raddr;
   } mem_req_type;

   // data memory address for an instruction; jumps bypass the mode decoder
   function automatic logic [15:0] mem_addr(input logic [7:0] ir, input logic [7:0] d,
                                            input logic [7:0] x, input logic [7:0] y);
      logic [15:0] addr;
      addr = {8'h00, d};
      if (ir[7:5] != OP_JMP) begin
         case (ir[4:2])
            MODE_X_AC:    addr = {8'h00, x};
            MODE_YD_AC:   addr = {y, d};
            MODE_YX_AC,
            MODE_YXI_OUT: addr = {y, x};
            default:      addr = {8'h00, d};
         endcase
      end
      return addr;
   endfunction

endpackage

// File: hw/rtl/thcc_exec.sv
// ----------------------------------------------------------------------------
// thcc_exec
// decode, bus select, alu and next pc for one machine cycle
// ----------------------------------------------------------------------------
module thcc_exec (
   input  thcc_pkg::arch_state_type cur,
   input  logic [7:0]               fetched_opcode,
   input  logic [7:0]               fetched_operand,
   input  logic [7:0]               button_port,
   input  logic [7:0]               floating_bus,
   input  logic                     hold_reset,
   input  logic [7:0]               ram_rdata,
   output thcc_pkg::arch_state_type nxt,
   output thcc_pkg::mem_req_type    mem_req
);

   logic [2:0]  ins;
   logic [2:0]  mode;
   logic [1:0]  bsel;
   logic        is_store;
   logic        is_jump;
   logic [15:0] addr;
   logic [7:0]  bus;
   logic [7:0]  alu;
   logic [15:0] pc0;
   logic        take;
   logic        a_zero;

   assign ins      = cur.ir[7:5];
   assign mode     = cur.ir[4:2];
   assign bsel     = cur.ir[1:0];
   assign is_store = (ins == thcc_pkg::OP_ST);
   assign is_jump  = (ins == thcc_pkg::OP_JMP);
   assign addr     = thcc_pkg::mem_addr(cur.ir, cur.d, cur.x, cur.y);
   assign pc0      = hold_reset ? 16'h0000 : cur.pc;
   assign a_zero   = (cur.ac == 8'h00);

   always_comb begin
      case (bsel)
         thcc_pkg::BUS_D:   bus = cur.d;
         thcc_pkg::BUS_RAM: bus = is_store ? floating_bus : ram_rdata;
         thcc_pkg::BUS_AC:  bus = cur.ac;
         default:           bus = button_port;
      endcase
   end

   always_comb begin
      case (ins)
         thcc_pkg::OP_LD:  alu = bus;
         thcc_pkg::OP_AND: alu = cur.ac & bus;
         thcc_pkg::OP_OR:  alu = cur.ac | bus;
         thcc_pkg::OP_XOR: alu = cur.ac ^ bus;
         thcc_pkg::OP_ADD: alu = cur.ac + bus;
         thcc_pkg::OP_SUB: alu = cur.ac - bus;
         thcc_pkg::OP_ST:  alu = cur.ac;
         default:          alu = 8'h00 - cur.ac;
      endcase
   end

   // branch condition: bit 0 gt, bit 1 negative, bit 2 zero
   assign take = (mode[0] & ~a_zero & ~(|(cur.ac & thcc_pkg::SIGN_BIT)))
               | (mode[1] & (|(cur.ac & thcc_pkg::SIGN_BIT)))
               | (mode[2] & a_zero);

   always_comb begin
      nxt    = cur;
      nxt.ir = fetched_opcode;
      nxt.d  = fetched_operand;
      if (!is_jump) begin
         unique case (mode)
            thcc_pkg::MODE_D_AC,
            thcc_pkg::MODE_X_AC,
            thcc_pkg::MODE_YD_AC,
            thcc_pkg::MODE_YX_AC: begin
               if (!is_store) nxt.ac = alu;
            end
            thcc_pkg::MODE_D_X:   nxt.x = alu;
            thcc_pkg::MODE_D_Y:   nxt.y = alu;
            thcc_pkg::MODE_D_OUT: begin
               if (!is_store) nxt.out_port = alu;
            end
            default: begin
               if (!is_store) nxt.out_port = alu;
               nxt.x = cur.x + 8'd1;
            end
         endcase
      end
      nxt.pc = pc0 + 16'd1;
      if (is_jump) begin
         if (mode == thcc_pkg::MODE_FAR) begin
            nxt.pc = {cur.y, bus};
         end else if (take) begin
            nxt.pc = (pc0 & thcc_pkg::PAGE_MASK) | {8'h00, bus};
         end
      end
      // extended output follows ac on a rising hsync
      if (|(nxt.out_port & thcc_pkg::HSYNC_BIT) && !(|(cur.out_port & thcc_pkg::HSYNC_BIT))) begin
         nxt.ext_out = nxt.ac;
      end
   end

   always_comb begin
      mem_req.we    = is_store;
      mem_req.waddr = addr;
      mem_req.wdata = bus;
      // prefetch for the instruction that executes next
      mem_req.raddr = thcc_pkg::mem_addr(fetched_opcode, fetched_operand, nxt.x, nxt.y);
   end

endmodule

// File: hw/rtl/ttl_harvard_cpu_cycle_unit.sv
// ----------------------------------------------------------------------------
// ttl_harvard_cpu_cycle_unit
// one clock of an 8-bit harvard ttl cpu per word, data ram in block memory
// ----------------------------------------------------------------------------
// usage
//   req channel: one word per machine cycle, carrying the rom word fetched at
//   the current pc (opcode and operand), the button port, the floating bus
//   value and a hold_reset flag that forces pc to zero for that cycle
//   rsp channel: one word per req word with pc, out, extended out and ac as
//   they stand after the cycle
//   throughput: one word per clock; the next word is taken while the previous
//   result waits, since req_ready only drops in reset or when rsp holds a word
//   and the receiver stalls
//   the result is registered and shows in the cycle after the req word is accepted
//   the data ram read for the instruction that executes next is issued at the
//   edge where the current word is accepted (address from the new ir, d, x, y),
//   so the registered memory read never stalls the machine; a store to the
//   same address at that edge is forwarded
//   reset: all cpu registers clear, rsp empties and req_ready stays low; the
//   data ram keeps its contents and no clearing pass runs
// ----------------------------------------------------------------------------
module ttl_harvard_cpu_cycle_unit #(
   parameter int unsigned RAM_DEPTH = thcc_pkg::RAM_DEPTH
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_fetched_opcode,
   input  logic [7:0]  req_fetched_operand,
   input  logic [7:0]  req_button_port,
   input  logic [7:0]  req_floating_bus,
   input  logic        req_hold_reset,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_next_pc,
   output logic [7:0]  rsp_out_port,
   output logic [7:0]  rsp_ext_out,
   output logic [7:0]  rsp_accumulator
);

   localparam int unsigned AW = $clog2(RAM_DEPTH);

   thcc_pkg::arch_state_type state_ff, state_in;
   thcc_pkg::mem_req_type    mem_req;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          accept;
   logic [7:0]    ram_q_ff;
   logic          fwd_ff;
   logic [7:0]    fwd_data_ff;
   logic [7:0]    ram_rdata;
   logic [7:0]    mem [RAM_DEPTH];

   // take a word unless in reset or a result is stuck at the output
   assign req_ready = !reset && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   // forwarded store data wins over the stale memory read
   assign ram_rdata = fwd_ff ? fwd_data_ff : ram_q_ff;

   thcc_exec u_exec (
      .cur             (state_ff),
      .fetched_opcode  (req_fetched_opcode),
      .fetched_operand (req_fetched_operand),
      .button_port     (req_button_port),
      .floating_bus    (req_floating_bus),
      .hold_reset      (req_hold_reset),
      .ram_rdata       (ram_rdata),
      .nxt             (state_in),
      .mem_req         (mem_req)
   );

   // data ram: a write for each accepted store and one registered read per accepted word
   always_ff @(posedge clock) begin
      if (accept) begin
         if (mem_req.we) begin
            mem[mem_req.waddr[AW-1:0]] <= mem_req.wdata;
         end
         ram_q_ff    <= mem[mem_req.raddr[AW-1:0]];
         fwd_data_ff <= mem_req.wdata;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         fwd_ff       <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            state_ff <= state_in;
            fwd_ff   <= mem_req.we && (mem_req.waddr[AW-1:0] == mem_req.raddr[AW-1:0]);
         end
      end
   end

   // state only moves on accept, so it doubles as the output register
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_next_pc     = state_ff.pc;
   assign rsp_out_port    = state_ff.out_port;
   assign rsp_ext_out     = state_ff.ext_out;
   assign rsp_accumulator = state_ff.ac;

`ifndef SYNTH
   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted word produced no result");

   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input stalled without a blocked result");

   a_hold_reset_pc: assert property (@(posedge clock) disable iff (reset)
      (accept && req_hold_reset && (state_ff.ir[7:5] != thcc_pkg::OP_JMP))
      |=> (rsp_next_pc == 16'd1))
      else $error("hold_reset did not restart pc");

   a_ext_out_on_hsync: assert property (@(posedge clock) disable iff (reset)
      (accept && !(|(state_in.out_port & thcc_pkg::HSYNC_BIT)
                   && !(|(state_ff.out_port & thcc_pkg::HSYNC_BIT))))
      |=> $stable(rsp_ext_out))
      else $error("extended output changed without hsync rise");
`endif

endmodule

// File: sim/ttl_harvard_cpu_cycle_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttl_harvard_cpu_cycle_unit_tb
// self-checking bench for the harvard cpu cycle unit. a cycle-accurate
// predictor of the cpu runs alongside the rtl. directed words cover every
// alu op, addressing mode, bus source and branch condition, and stores in
// several modes. random traffic follows, with idle and stall patterns on both
// channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module ttl_harvard_cpu_cycle_unit_tb;

   // branch condition masks for jumps, bit 0 gt, bit 1 lt, bit 2 eq
   localparam logic [2:0] COND_GT     = 3'b001;
   localparam logic [2:0] COND_LT     = 3'b010;
   localparam logic [2:0] COND_EQ     = 3'b100;
   localparam logic [2:0] COND_ALWAYS = 3'b111;

   localparam logic [15:0] RAM_MASK = 16'(thcc_pkg::RAM_DEPTH - 1);

   typedef enum logic [2:0] {DST_NONE, DST_AC, DST_X, DST_Y, DST_OUT} dest_type;

   typedef struct packed {
      logic [15:0] pc;
      logic [7:0]  out_port;
      logic [7:0]  ext_out;
      logic [7:0]  ac;
   } cycle_result_type;

   // dut ports, every input driven to a known value from time zero
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_fetched_opcode = 8'h00;
   logic [7:0]  req_fetched_operand = 8'h00;
   logic [7:0]  req_button_port = 8'h00;
   logic [7:0]  req_floating_bus = 8'h00;
   logic        req_hold_reset = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_next_pc;
   logic [7:0]  rsp_out_port;
   logic [7:0]  rsp_ext_out;
   logic [7:0]  rsp_accumulator;

   // predicted machine state
   logic [15:0] cpu_pc  = 16'h0000;
   logic [7:0]  cpu_ir  = 8'h00;
   logic [7:0]  cpu_d   = 8'h00;
   logic [7:0]  cpu_ac  = 8'h00;
   logic [7:0]  cpu_x   = 8'h00;
   logic [7:0]  cpu_y   = 8'h00;
   logic [7:0]  cpu_out = 8'h00;
   logic [7:0]  cpu_ext = 8'h00;
   logic [7:0]  cpu_ram [thcc_pkg::RAM_DEPTH];
   bit          ram_written [thcc_pkg::RAM_DEPTH];

   cycle_result_type predicted_cycles[$];

   int error_count = 0;
   int words_sent = 0;
   int results_checked = 0;
   int stores_seen = 0;
   int ram_reads_seen = 0;
   int jumps_taken = 0;

   // idle rates in percent, and the long receiver hold-off request
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int stall_request = 0;

   ttl_harvard_cpu_cycle_unit i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_fetched_opcode  (req_fetched_opcode),
      .req_fetched_operand (req_fetched_operand),
      .req_button_port     (req_button_port),
      .req_floating_bus    (req_floating_bus),
      .req_hold_reset      (req_hold_reset),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_next_pc         (rsp_next_pc),
      .rsp_out_port        (rsp_out_port),
      .rsp_ext_out         (rsp_ext_out),
      .rsp_accumulator     (rsp_accumulator)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // hard stop well past the slowest legal run
   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // ------------------------------------------------------------------------
   // predictor: executes the instruction held in ir/d for one machine cycle
   // ir/d are latched by the caller, after the fetched word is made safe
   // ------------------------------------------------------------------------
   task automatic execute_machine_cycle(input logic [7:0] port, input logic [7:0] flt,
                                        input logic hold, output cycle_result_type res);
      logic [15:0] pc;
      logic [15:0] addr;
      logic [15:0] npc;
      logic [7:0]  lo;
      logic [7:0]  hi;
      logic [7:0]  bus;
      logic [7:0]  alu;
      logic [7:0]  old_out;
      logic [7:0]  old_x;
      logic [7:0]  acc_in;
      logic [2:0]  ins;
      logic [2:0]  mode;
      logic [1:0]  bsel;
      dest_type    dest;
      logic        bump_x;
      int          cond;

      pc     = hold ? 16'h0000 : cpu_pc;
      ins    = cpu_ir[7:5];
      mode   = cpu_ir[4:2];
      bsel   = cpu_ir[1:0];
      lo     = cpu_d;
      hi     = 8'h00;
      dest   = DST_NONE;
      bump_x = 1'b0;
      acc_in = cpu_ac;

      // jumps skip the mode decoder entirely
      if (ins != thcc_pkg::OP_JMP) begin
         case (mode)
            thcc_pkg::MODE_D_AC:  dest = DST_AC;
            thcc_pkg::MODE_X_AC:  begin dest = DST_AC; lo = cpu_x; end
            thcc_pkg::MODE_YD_AC: begin dest = DST_AC; hi = cpu_y; end
            thcc_pkg::MODE_YX_AC: begin dest = DST_AC; lo = cpu_x; hi = cpu_y; end
            thcc_pkg::MODE_D_X:   dest = DST_X;
            thcc_pkg::MODE_D_Y:   dest = DST_Y;
            thcc_pkg::MODE_D_OUT: dest = DST_OUT;
            default: begin
               dest = DST_OUT; lo = cpu_x; hi = cpu_y; bump_x = 1'b1;
            end
         endcase
         // stores never load ac or out, x and y still load
         if (ins == thcc_pkg::OP_ST && (dest == DST_AC || dest == DST_OUT)) dest = DST_NONE;
      end

      addr = {hi, lo} & RAM_MASK;
      case (bsel)
         thcc_pkg::BUS_D:   bus = cpu_d;
         thcc_pkg::BUS_RAM: begin
            if (ins == thcc_pkg::OP_ST) begin
               bus = flt;
            end else begin
               bus = cpu_ram[addr];
               ram_reads_seen++;
            end
         end
         thcc_pkg::BUS_AC:  bus = cpu_ac;
         default:           bus = port;
      endcase

      if (ins == thcc_pkg::OP_ST) begin
         cpu_ram[addr] = bus;
         ram_written[addr] = 1'b1;
         stores_seen++;
      end

      case (ins)
         thcc_pkg::OP_LD:   alu = bus;
         thcc_pkg::OP_AND:  alu = acc_in & bus;
         thcc_pkg::OP_OR:   alu = acc_in | bus;
         thcc_pkg::OP_XOR:  alu = acc_in ^ bus;
         thcc_pkg::OP_ADD:  alu = acc_in + bus;
         thcc_pkg::OP_SUB:  alu = acc_in - bus;
         thcc_pkg::OP_ST:   alu = acc_in;
         default:           alu = 8'h00 - acc_in;
      endcase

      old_out = cpu_out;
      old_x   = cpu_x;
      case (dest)
         DST_AC:  cpu_ac  = alu;
         DST_X:   cpu_x   = alu;
         DST_Y:   cpu_y   = alu;
         DST_OUT: cpu_out = alu;
         default: ;
      endcase
      if (bump_x) cpu_x = old_x + 8'h01;

      npc = pc + 16'h0001;
      if (ins == thcc_pkg::OP_JMP) begin
         if (mode != thcc_pkg::MODE_FAR) begin
            // condition index from ac before the cycle: 0 gt, 1 lt, 2 eq
            if (acc_in == 8'h00) cond = 2;
            else if ((acc_in & thcc_pkg::SIGN_BIT) != 0) cond = 1;
            else cond = 0;
            if (mode[cond]) begin
               npc = (pc & thcc_pkg::PAGE_MASK) | {8'h00, bus};
               jumps_taken++;
            end
         end else begin
            npc = {cpu_y, bus};
            jumps_taken++;
         end
      end

      // extended output follows ac on a rising hsync
      if ((cpu_out & thcc_pkg::HSYNC_BIT) != 0 && (old_out & thcc_pkg::HSYNC_BIT) == 0)
         cpu_ext = cpu_ac;

      cpu_pc = npc;
      res = '{pc: cpu_pc, out_port: cpu_out, ext_out: cpu_ext, ac: cpu_ac};
   endtask

   // a fetched word that would read a never-written ram byte when it executes
   // falls back to the operand as bus source
   function automatic logic [7:0] guard_ram_read(input logic [7:0] opcode,
                                                 input logic [7:0] operand);
      logic [15:0] addr;
      addr = {8'h00, operand};
      if (opcode[1:0] != thcc_pkg::BUS_RAM || opcode[7:5] == thcc_pkg::OP_ST) return opcode;
      if (opcode[7:5] != thcc_pkg::OP_JMP) begin
         case (opcode[4:2])
            thcc_pkg::MODE_X_AC:    addr = {8'h00, cpu_x};
            thcc_pkg::MODE_YD_AC:   addr = {cpu_y, operand};
            thcc_pkg::MODE_YX_AC,
            thcc_pkg::MODE_YXI_OUT: addr = {cpu_y, cpu_x};
            default:                addr = {8'h00, operand};
         endcase
      end
      if (!ram_written[addr & RAM_MASK]) return {opcode[7:2], thcc_pkg::BUS_D};
      return opcode;
   endfunction

   // ------------------------------------------------------------------------
   // req side: offers one word, entered and left at a falling edge
   // valid stays high between back-to-back words
   // ------------------------------------------------------------------------
   task automatic exec_word(input logic [7:0] opcode, input logic [7:0] operand,
                            input logic [7:0] port, input logic [7:0] flt,
                            input logic hold);
      cycle_result_type res;
      logic [7:0]       safe_op;

      execute_machine_cycle(port, flt, hold, res);
      safe_op = guard_ram_read(opcode, operand);
      cpu_ir  = safe_op;
      cpu_d   = operand;

      // each cycle idles with the given percentage
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_fetched_opcode  <= safe_op;
      req_fetched_operand <= operand;
      req_button_port     <= port;
      req_floating_bus    <= flt;
      req_hold_reset      <= hold;
      do @(posedge clock); while (!req_ready);
      predicted_cycles.push_back(res);
      words_sent++;
      @(negedge clock);
   endtask

   // sender goes quiet until every predicted word has come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (predicted_cycles.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // rsp side: random ready, plus a counted hold-off on request
   // ------------------------------------------------------------------------
   initial begin : rsp_driver
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_request != 0) begin
            stall_left = stall_request;
            stall_request = 0;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
         error_count++;
      end
   endtask

   // every accepted result word against the oldest prediction
   always @(posedge clock) begin : rsp_check
      cycle_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_cycles.size() == 0) begin
            $display("%0t ns: unexpected result word, expected none, actual pc %h",
                     $time, rsp_next_pc);
            error_count++;
         end else begin
            want = predicted_cycles.pop_front();
            check_field("next_pc", want.pc, rsp_next_pc);
            check_field("out_port", {8'h00, want.out_port}, {8'h00, rsp_out_port});
            check_field("ext_out", {8'h00, want.ext_out}, {8'h00, rsp_ext_out});
            check_field("accumulator", {8'h00, want.ac}, {8'h00, rsp_accumulator});
            results_checked++;
         end
      end
   end

   // ------------------------------------------------------------------------
   // directed tests; each word's instruction executes on the following word
   // ------------------------------------------------------------------------
   task automatic test_alu_and_addressing();
      exec_word({thcc_pkg::OP_LD, thcc_pkg::MODE_D_AC, thcc_pkg::BUS_D},
                8'hff, 8'h00, 8'hff, 1'b0);
      exec_word({thcc_pkg::OP_ST, thcc_pkg::MODE_D_AC, thcc_pkg::BUS_AC},
                8'h10, 8'hff, 8'h00, 1'b0);
      // store of the floating bus, value taken from the word after it
      exec_word({thcc_pkg::OP_ST, thcc_pkg::MODE_D_AC, thcc_pkg::BUS_RAM},
                8'h11, 8'h00, 8'hff, 1'b0);
      exec_word({thcc_pkg::OP_LD, thcc_pkg::MODE_D_X, thcc_pkg::BUS_D},
                8'h11, 8'h00, 8'ha5, 1'b0);
      exec_word({thcc_pkg::OP_LD, thcc_pkg::MODE_D_Y, thcc_pkg::BUS_D},
                8'h00, 8'hff, 8'h00, 1'b0);
      exec_word({thcc_pkg::OP_AND, thcc_pkg::MODE_X_AC, thcc_pkg::BUS_RAM},
                8'h00, 8'h00, 8'hff, 1'b0);
      exec_word({thcc_pkg::OP_OR, thcc_pkg::MODE_YD_AC, thcc_pkg::BUS_RAM},
                8'h10, 8'hff, 8'h00, 1'b0);
      exec_word({thcc_pkg::OP_XOR, thcc_pkg::MODE_D_AC, thcc_pkg::BUS_IN},
                8'h00, 8'h00, 8'hff, 1'b0);
      exec_word({thcc_pkg::OP_ADD, thcc_pkg::MODE_D_AC, thcc_pkg::BUS_D},
                8'h01, 8'h3c, 8'h00, 1'b0);
      exec_word({thcc_pkg::OP_SUB, thcc_pkg::MODE_D_AC, thcc_pkg::BUS_AC},
                8'h00, 8'hff, 8'hff, 1'b0);
   endtask

   // stores leave ac and out alone but still load x or y, and post-increment x
   task automatic test_store_modes();
      exec_word({thcc_pkg::OP_ST, thcc_pkg::MODE_YXI_OUT, thcc_pkg::BUS_AC},
                8'h00, 8'h00, 8'h00, 1'b0);
      exec_word({thcc_pkg::OP_ST, thcc_pkg::MODE_D_X, thcc_pkg::BUS_D},
                8'h12, 8'hff, 8'hff, 1'b0);
      exec_word({thcc_pkg::OP_ST, thcc_pkg::MODE_D_Y, thcc_pkg::BUS_D},
                8'h13, 8'h00, 8'h00, 1'b0);
      exec_word({thcc_pkg::OP_ST, thcc_pkg::MODE_YX_AC, thcc_pkg::BUS_IN},
                8'h00, 8'hc3, 8'hff, 1'b0);
   endtask

   // rising hsync latches ac into the extended output
   task automatic test_output_latch();
      exec_word({thcc_pkg::OP_LD, thcc_pkg::MODE_D_OUT, thcc_pkg::BUS_D},
                thcc_pkg::HSYNC_BIT, 8'h5a, 8'h00, 1'b0);
      exec_word({thcc_pkg::OP_LD, thcc_pkg::MODE_YXI_OUT, thcc_pkg::BUS_D},
                8'h00, 8'hff, 8'hff, 1'b0);
   endtask

   task automatic test_branches();
      exec_word({thcc_pkg::OP_LD, thcc_pkg::MODE_D_AC, thcc_pkg::BUS_D},
                thcc_pkg::SIGN_BIT, 8'h00, 8'h00, 1'b0);
      exec_word({thcc_pkg::OP_JMP, COND_LT, thcc_pkg::BUS_D},
                8'h33, 8'hff, 8'hff, 1'b0);
      exec_word({thcc_pkg::OP_JMP, COND_GT, thcc_pkg::BUS_D},
                8'h44, 8'h00, 8'h00, 1'b0);
      // far jump reading ram at the operand, upper address byte zero
      exec_word({thcc_pkg::OP_JMP, thcc_pkg::MODE_FAR, thcc_pkg::BUS_RAM},
                8'h10, 8'hff, 8'hff, 1'b0);
      exec_word({thcc_pkg::OP_LD, thcc_pkg::MODE_D_AC, thcc_pkg::BUS_D},
                8'h00, 8'h00, 8'h00, 1'b0);
      exec_word({thcc_pkg::OP_JMP, COND_EQ, thcc_pkg::BUS_AC},
                8'h00, 8'hff, 8'hff, 1'b0);
      exec_word({thcc_pkg::OP_JMP, COND_ALWAYS, thcc_pkg::BUS_IN},
                8'h00, 8'h81, 8'h00, 1'b0);
   endtask

   task automatic test_hold_reset();
      exec_word({thcc_pkg::OP_LD, thcc_pkg::MODE_D_AC, thcc_pkg::BUS_D},
                8'h7f, 8'hff, 8'h00, 1'b1);
      exec_word({thcc_pkg::OP_LD, thcc_pkg::MODE_D_AC, thcc_pkg::BUS_D},
                8'h01, 8'h00, 8'hff, 1'b0);
   endtask

   // random words, stores favored so that ram reads find written bytes
   task automatic test_random_traffic(input int count, input int send_pct,
                                      input int recv_pct);
      logic [7:0] opcode;
      logic [7:0] operand;
      logic       hold;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int i = 0; i < count; i++) begin
         opcode = 8'($urandom_range(255));
         if ($urandom_range(99) < 20) opcode[7:5] = thcc_pkg::OP_ST;
         operand = ($urandom_range(1) == 0) ? 8'($urandom_range(15))
                                            : 8'($urandom_range(255));
         hold = ($urandom_range(99) < 2);
         exec_word(opcode, operand, 8'($urandom_range(255)), 8'($urandom_range(255)),
                   hold);
      end
      wait_for_drain();
   endtask

   // long receiver hold-off while the sender keeps offering, then a full pause
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      stall_request = 200;
      @(negedge clock);
      for (int i = 0; i < 40; i++)
         exec_word(8'($urandom_range(255)), 8'($urandom_range(15)),
                   8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0);
      wait_for_drain();
      for (int i = 0; i < 20; i++)
         exec_word(8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0);
      wait_for_drain();
   endtask

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin : main_seq
      int guard;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_alu_and_addressing();
      test_store_modes();
      test_output_latch();
      test_branches();
      test_hold_reset();
      wait_for_drain();

      test_random_traffic(360, 15, 60);
      test_random_traffic(360, 60, 15);
      test_random_traffic(360, 0, 0);
      test_backpressure();

      // let the last words settle, bounded
      req_valid <= 1'b0;
      guard = 0;
      while (predicted_cycles.size() != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
      repeat (8) @(posedge clock);
      if (predicted_cycles.size() != 0) begin
         $display("%0t ns: %0d predicted words never arrived, expected 0, actual %0d",
                  $time, predicted_cycles.size(), predicted_cycles.size());
         error_count++;
      end

      $display("ran %0d machine cycles, %0d results compared, %0d mismatches",
               words_sent, results_checked, error_count);
      $display("exercised %0d stores, %0d ram reads, %0d taken jumps",
               stores_seen, ram_reads_seen, jumps_taken);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// File: files.f
hw/rtl/thcc_pkg.sv
hw/rtl/thcc_exec.sv
hw/rtl/ttl_harvard_cpu_cycle_unit.sv
sim/ttl_harvard_cpu_cycle_unit_tb.sv
